/* hw/rtl/wwpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwpf_pkg: shared types and constants of the weighted window peak finder
// Field widths, default window size and the tag that travels with each
// transaction down the scoring pipeline.
// ----------------------------------------------------------------------------
package wwpf_pkg;

    localparam int POS_W        = 16;
    localparam int COUNT_W      = 20;
    localparam int WINDOW_SIZE_DEF = 8;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic vld;
        logic score_en;
        logic last;
        pos_t pos;
        pos_t fb_pos;
    } tag_t;

endpackage

/* hw/rtl/wwpf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwpf_window: window shift line, fill count and fallback tracking
// Holds the last WINDOW_SIZE counts, tracks the short-range fallback and
// registers a snapshot of the full window for scoring.
// ----------------------------------------------------------------------------
module wwpf_window #(
    parameter int WINDOW_SIZE = wwpf_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic                                     advance,
    input  wwpf_pkg::pos_t                           position,
    input  wwpf_pkg::count_t                         count,
    input  logic                                     last_item,
    output wwpf_pkg::tag_t                           a_tag,
    output logic [WINDOW_SIZE:0][wwpf_pkg::COUNT_W-1:0] a_cnt
);
    import wwpf_pkg::*;

    localparam int HALF   = WINDOW_SIZE / 2;
    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);

    count_t [WINDOW_SIZE-1:0] cnt_tap_reg;
    pos_t   [WINDOW_SIZE-1:0] pos_tap_reg;
    logic [FILL_W-1:0]        fill_reg;
    count_t                   fb_cnt_reg;
    pos_t                     fb_pos_reg;
    tag_t                     a_tag_reg;
    logic [WINDOW_SIZE:0][COUNT_W-1:0] a_cnt_reg;

    logic full;
    logic fb_upd;
    pos_t fb_pos_now;

    assign full       = (fill_reg == FILL_W'(WINDOW_SIZE));
    assign fb_upd     = !full && (count > fb_cnt_reg);
    assign fb_pos_now = fb_upd ? position : fb_pos_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++)
            begin
                cnt_tap_reg[i] <= cnt_tap_reg[i+1];
                pos_tap_reg[i] <= pos_tap_reg[i+1];
            end
            cnt_tap_reg[WINDOW_SIZE-1] <= count;
            pos_tap_reg[WINDOW_SIZE-1] <= position;
        end
        if (advance)
        begin
            a_cnt_reg[WINDOW_SIZE-1:0] <= cnt_tap_reg;
            a_cnt_reg[WINDOW_SIZE]     <= count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            fb_cnt_reg <= '0;
            fb_pos_reg <= '0;
            a_tag_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (last_item)
                begin
                    fill_reg   <= '0;
                    fb_cnt_reg <= '0;
                    fb_pos_reg <= '0;
                end
                else if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fb_upd)
                    begin
                        fb_cnt_reg <= count;
                        fb_pos_reg <= position;
                    end
                end
            end
            if (advance)
            begin
                a_tag_reg.vld      <= accept;
                a_tag_reg.score_en <= full;
                a_tag_reg.last     <= last_item;
                a_tag_reg.pos      <= pos_tap_reg[HALF];
                a_tag_reg.fb_pos   <= fb_pos_now;
            end
        end
    end

    assign a_tag = a_tag_reg;
    assign a_cnt = a_cnt_reg;

endmodule

/* hw/rtl/wwpf_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwpf_score: weighted window score
// Divides each neighbour count by its distance plus one through a constant
// reciprocal multiply, registers the quotients, then registers their sum.
// ----------------------------------------------------------------------------
module wwpf_score #(
    parameter int WINDOW_SIZE = wwpf_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        advance,
    input  wwpf_pkg::tag_t                              a_tag,
    input  logic [WINDOW_SIZE:0][wwpf_pkg::COUNT_W-1:0] a_cnt,
    output wwpf_pkg::tag_t                              c_tag,
    output logic [wwpf_pkg::COUNT_W+$clog2(WINDOW_SIZE+1)-1:0] c_sum
);
    import wwpf_pkg::*;

    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int SUM_W = COUNT_W + $clog2(WINDOW_SIZE + 1);

    count_t [WINDOW_SIZE:0] q_now;
    count_t [WINDOW_SIZE:0] b_q_reg;
    tag_t                   b_tag_reg;
    tag_t                   c_tag_reg;
    logic [SUM_W-1:0]       c_sum_reg;
    logic [SUM_W-1:0]       sum_next;

    for (genvar k = 0; k <= WINDOW_SIZE; k++)
    begin : g_lane
        if (k == HALF)
        begin : g_centre
            assign q_now[k] = a_cnt[k];
        end
        else
        begin : g_side
            localparam int DIV    = ((k > HALF) ? (k - HALF) : (HALF - k)) + 1;
            localparam int SHIFT  = COUNT_W + $clog2(DIV);
            localparam int PROD_W = SHIFT + COUNT_W;
            localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIV - 1) / DIV;
            logic [PROD_W-1:0] prod;
            assign prod     = PROD_W'(a_cnt[k]) * PROD_W'(MULT);
            assign q_now[k] = prod[SHIFT +: COUNT_W];
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k <= WINDOW_SIZE; k++)
        begin
            sum_next = sum_next + SUM_W'(b_q_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_q_reg   <= q_now;
            c_sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_tag_reg <= '0;
            c_tag_reg <= '0;
        end
        else if (advance)
        begin
            b_tag_reg <= a_tag;
            c_tag_reg <= b_tag_reg;
        end
    end

    assign c_tag = c_tag_reg;
    assign c_sum = c_sum_reg;

endmodule

/* hw/rtl/wwpf_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwpf_select: running best and result register
// Keeps the first strictly best score of the range and registers the peak
// position on the final transaction (a fallback if that one is unscored).
// ----------------------------------------------------------------------------
module wwpf_select #(
    parameter int WINDOW_SIZE = wwpf_pkg::WINDOW_SIZE_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               advance,
    input  wwpf_pkg::tag_t                                     c_tag,
    input  logic [wwpf_pkg::COUNT_W+$clog2(WINDOW_SIZE+1)-1:0] c_sum,
    input  logic                                               out_ready,
    output logic                                               out_valid,
    output wwpf_pkg::pos_t                                     peak_position
);
    import wwpf_pkg::*;

    localparam int SUM_W = COUNT_W + $clog2(WINDOW_SIZE + 1);

    logic [SUM_W-1:0] best_score_reg;
    pos_t             best_pos_reg;
    logic             out_valid_reg;
    pos_t             peak_reg;

    logic win;
    logic take;
    pos_t result;

    assign win    = c_tag.score_en && (c_sum > best_score_reg);
    assign take   = advance && c_tag.vld;
    assign result = c_tag.score_en ? (win ? c_tag.pos : best_pos_reg) : c_tag.fb_pos;

    always_ff @(posedge clk)
    begin
        if (take && c_tag.last)
        begin
            peak_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (c_tag.last)
                begin
                    best_score_reg <= '0;
                    best_pos_reg   <= '0;
                end
                else if (win)
                begin
                    best_score_reg <= c_sum;
                    best_pos_reg   <= c_tag.pos;
                end
            end
            if (take && c_tag.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign peak_position = peak_reg;

endmodule

/* hw/rtl/weighted_window_peak_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_window_peak_finder: sliding window peak search over a count stream
// Scores the centre of each full window, keeps the first strictly best peak
// and reports its position (or a fallback) on a range's final transaction.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    position, count, last_item
//   output    out_valid / out_ready  peak_position
//
// One transaction is taken every cycle unless the pipeline stalls; the window
// snapshot is registered at the accepting edge, then the quotient, sum and
// compare stages follow in that order up to the result register.
// After reset no clearing pass is needed; the range state is clear.
// The pipeline halts only when a result reaches the compare stage while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module weighted_window_peak_finder #(
    parameter int WINDOW_SIZE = wwpf_pkg::WINDOW_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wwpf_pkg::pos_t   position,
    input  wwpf_pkg::count_t count,
    input  logic             last_item,
    output logic             out_valid,
    input  logic             out_ready,
    output wwpf_pkg::pos_t   peak_position
);
    import wwpf_pkg::*;

    localparam int SUM_W = COUNT_W + $clog2(WINDOW_SIZE + 1);

    tag_t                              a_tag;
    logic [WINDOW_SIZE:0][COUNT_W-1:0] a_cnt;
    tag_t                              c_tag;
    logic [SUM_W-1:0]                  c_sum;
    logic                              stall;
    logic                              advance;
    logic                              accept;

    // hold everything while a second result would overwrite a waiting one
    assign stall    = c_tag.vld && c_tag.last && out_valid && !out_ready;
    assign advance  = !stall;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    wwpf_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .position  (position),
        .count     (count),
        .last_item (last_item),
        .a_tag     (a_tag),
        .a_cnt     (a_cnt)
    );

    wwpf_score #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_score (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .a_tag   (a_tag),
        .a_cnt   (a_cnt),
        .c_tag   (c_tag),
        .c_sum   (c_sum)
    );

    wwpf_select #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .c_tag         (c_tag),
        .c_sum         (c_sum),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .peak_position (peak_position)
    );

endmodule
